@@ src/wsd_pkg.sv @@
`default_nettype none

package wsd_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  body_byte;
    logic [31:0] peer_id;
    logic [31:0] route_id;
    logic [15:0] message_length;
    logic        last;
  } out_word_t;

  typedef enum logic [3:0] {
    PhB0   = 4'd0,
    PhB1   = 4'd1,
    PhB1C  = 4'd2,
    PhL16  = 4'd3,
    PhL64  = 4'd4,
    PhDlen = 4'd5,
    PhMask = 4'd6,
    PhBhdr = 4'd7,
    PhBody = 4'd8,
    PhSkip = 4'd9
  } phase_e;

  localparam int unsigned MaxFrameW = 17;

  localparam logic [2:0] KindBody     = 3'd0;
  localparam logic [2:0] KindEmpty    = 3'd1;
  localparam logic [2:0] KindClose    = 3'd2;
  localparam logic [2:0] KindTooLarge = 3'd3;
  localparam logic [2:0] KindTooShort = 3'd4;
  localparam logic [2:0] KindMismatch = 3'd5;

  localparam logic [MaxFrameW-1:0] MaxFrameReset = 17'd65536;

  localparam logic [3:0]  OpClose   = 4'h8;
  localparam logic [6:0]  Len16Code = 7'd126;
  localparam logic [6:0]  Len64Code = 7'd127;
  localparam logic [3:0]  MaskLen   = 4'd4;
  localparam logic [3:0]  BhdrLen   = 4'd12;
  localparam logic [63:0] BhdrLen64 = 64'd12;

endpackage

`default_nettype wire

@@ src/websocket_frame_deframer_core.sv @@
// WebSocket deframer: one received byte is taken per word and the block sustains one word per
// clock while the output is not stalled. Each word passes an input register, the header parser
// and unmasking logic, and an output register, from which its result is presented. The input
// side stalls only while a finished result waits at a stalled output. There is no clearing pass
// after reset, and the frame size limit may be rewritten only while the block is idle.
`default_nettype none

module websocket_frame_deframer_core (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_stall_o,
  input  wsd_pkg::in_word_t             in_word_i,
  output logic                          out_valid_o,
  input  wire                           out_stall_i,
  output wsd_pkg::out_word_t            out_word_o,
  input  wire                           cfg_we_i,
  input  wire [wsd_pkg::MaxFrameW-1:0]  cfg_wdata_i
);
  import wsd_pkg::*;

  logic                 a_valid_q, a_valid_d;
  in_word_t             a_word_q;
  logic                 out_valid_q, out_valid_d;
  out_word_t            out_word_q;
  logic [MaxFrameW-1:0] max_frame_q;
  logic                 advance;
  logic                 accept;
  logic                 res_valid;
  out_word_t            res_word;

  assign advance    = a_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = a_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    if (accept) begin
      a_valid_d = 1'b1;
    end else if (advance) begin
      a_valid_d = 1'b0;
    end else begin
      a_valid_d = a_valid_q;
    end
    if (advance) begin
      out_valid_d = res_valid;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  wsd_parser u_parser (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .fire_i            (advance),
    .word_i            (a_word_q),
    .max_frame_bytes_i (max_frame_q),
    .res_valid_o       (res_valid),
    .res_word_o        (res_word)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      max_frame_q <= MaxFrameReset;
    end else begin
      a_valid_q   <= a_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        max_frame_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_word_q <= in_word_i;
    end
    if (advance && res_valid) begin
      out_word_q <= res_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

`ifndef ASSERT_OFF
  a_stall_needs_blocked_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result");

  a_kind_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.kind <= KindMismatch))
    else $error("result kind out of range");

  a_report_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_word_o.kind != KindBody)) |-> out_word_o.last)
    else $error("report without last");

  a_report_no_ids : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ((out_word_o.kind == KindClose) || (out_word_o.kind == KindTooLarge) ||
                     (out_word_o.kind == KindTooShort)))
    |-> ((out_word_o.peer_id == 32'd0) && (out_word_o.route_id == 32'd0) &&
         (out_word_o.message_length == 16'd0) && (out_word_o.body_byte == 8'd0)))
    else $error("header report carries ids or data");
`endif

endmodule

`default_nettype wire

@@ src/wsd_parser.sv @@
`default_nettype none

module wsd_parser (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               fire_i,
  input  wsd_pkg::in_word_t                 word_i,
  input  wire [wsd_pkg::MaxFrameW-1:0]      max_frame_bytes_i,
  output logic                              res_valid_o,
  output wsd_pkg::out_word_t                res_word_o
);
  import wsd_pkg::*;

  phase_e      phase_q, phase_d;
  logic        final_q, final_d;
  logic        masked_q, masked_d;
  logic [63:0] accum_q, accum_d;
  logic [3:0]  hbc_q, hbc_d;
  logic [31:0] mask_q, mask_d;
  logic [63:0] pidx_q, pidx_d;
  logic [31:0] client_q, client_d;
  logic [31:0] backend_q, backend_d;
  logic [31:0] blen_q, blen_d;

  phase_e      cur_phase;
  logic [63:0] cur_accum;
  logic [3:0]  cur_hbc;
  logic [63:0] cur_pidx;
  logic [7:0]  b;
  logic [6:0]  l7;
  logic        ext_len;
  logic        in_b1;
  logic        in_len;
  logic [3:0]  hbc_dec;
  logic [63:0] accum_shift;
  logic        ld_masked;
  logic [63:0] ld_len;
  logic [3:0]  ld_ext;
  logic [3:0]  ld_hdr;
  logic [64:0] ld_sum;
  logic [64:0] ld_nsum;
  logic [63:0] ld_n;
  logic        ld_drop;
  logic        len_event;
  logic        too_large;
  logic        too_short;
  logic        ld_skip;
  logic [7:0]  key_byte;
  logic [7:0]  ub;
  logic [63:0] pidx_inc;
  logic [63:0] accum_minus;
  logic        mismatch;
  logic        body_fin;

  assign cur_phase = word_i.restart ? PhB0 : phase_q;
  assign cur_accum = word_i.restart ? 64'd0 : accum_q;
  assign cur_hbc   = word_i.restart ? 4'd0 : hbc_q;
  assign cur_pidx  = word_i.restart ? 64'd0 : pidx_q;

  assign b       = word_i.data_byte;
  assign l7      = b[6:0];
  assign ext_len = (l7 == Len16Code) || (l7 == Len64Code);
  assign in_b1   = (cur_phase == PhB1) || (cur_phase == PhB1C);
  assign in_len  = (cur_phase == PhL16) || (cur_phase == PhL64) || (cur_phase == PhDlen);
  assign hbc_dec = cur_hbc - 4'd1;
  assign accum_shift = {cur_accum[55:0], b};

  assign ld_masked = in_b1 ? b[7] : masked_q;
  assign ld_len    = in_b1 ? {57'd0, l7} : accum_shift;
  assign ld_ext    = (cur_phase == PhL16) ? 4'd2 : ((cur_phase == PhL64) ? 4'd8 : 4'd0);
  assign ld_hdr    = 4'd2 + ld_ext + (ld_masked ? MaskLen : 4'd0);
  assign ld_sum    = {1'b0, ld_len} + {61'd0, ld_hdr};
  assign ld_nsum   = {1'b0, ld_len} + {62'd0, ld_masked, 2'b00};
  assign ld_n      = ld_nsum[64] ? '1 : ld_nsum[63:0];
  assign ld_drop   = in_b1 ? ((cur_phase == PhB1C) || !final_q) : (cur_phase == PhDlen);
  assign len_event = (in_b1 && !ext_len) || (in_len && (hbc_dec == 4'd0));
  assign too_large = ld_sum > {48'd0, max_frame_bytes_i};
  assign too_short = ld_len < BhdrLen64;
  assign ld_skip   = ld_drop || too_large || too_short;

  always_comb begin
    unique case (cur_pidx[1:0])
      2'd0:    key_byte = mask_q[31:24];
      2'd1:    key_byte = mask_q[23:16];
      2'd2:    key_byte = mask_q[15:8];
      default: key_byte = mask_q[7:0];
    endcase
  end

  // The last backend header byte lands in the backend id, so the length word is already final.
  assign ub          = b ^ key_byte;
  assign pidx_inc    = cur_pidx + 64'd1;
  assign accum_minus = cur_accum - BhdrLen64;
  assign mismatch    = {32'd0, blen_q} != accum_minus;
  assign body_fin    = pidx_inc >= cur_accum;

  always_comb begin
    phase_d   = cur_phase;
    final_d   = final_q;
    masked_d  = masked_q;
    accum_d   = cur_accum;
    hbc_d     = cur_hbc;
    mask_d    = mask_q;
    pidx_d    = cur_pidx;
    client_d  = client_q;
    backend_d = backend_q;
    blen_d    = blen_q;
    unique case (cur_phase)
      PhB0: begin
        final_d = b[7];
        phase_d = (b[3:0] == OpClose) ? PhB1C : PhB1;
      end
      PhB1, PhB1C, PhL16, PhL64, PhDlen: begin
        if (in_b1) begin
          masked_d = b[7];
        end else begin
          hbc_d = hbc_dec;
        end
        accum_d = ld_len;
        if (in_b1 && ext_len) begin
          accum_d = 64'd0;
          hbc_d   = (l7 == Len16Code) ? 4'd2 : 4'd8;
          if (ld_drop) begin
            phase_d = PhDlen;
          end else begin
            phase_d = (l7 == Len16Code) ? PhL16 : PhL64;
          end
        end else if (len_event) begin
          if (ld_skip) begin
            pidx_d  = ld_n;
            phase_d = (ld_n == 64'd0) ? PhB0 : PhSkip;
          end else begin
            pidx_d = 64'd0;
            if (ld_masked) begin
              phase_d = PhMask;
              hbc_d   = MaskLen;
            end else begin
              mask_d  = 32'd0;
              phase_d = PhBhdr;
              hbc_d   = BhdrLen;
            end
          end
        end
      end
      PhMask: begin
        mask_d = {mask_q[23:0], b};
        hbc_d  = hbc_dec;
        if (hbc_dec == 4'd0) begin
          phase_d = PhBhdr;
          hbc_d   = BhdrLen;
          pidx_d  = 64'd0;
        end
      end
      PhBhdr: begin
        if (cur_pidx[3:0] < 4'd4) begin
          blen_d = {blen_q[23:0], ub};
        end else if (cur_pidx[3:0] < 4'd8) begin
          client_d = {client_q[23:0], ub};
        end else begin
          backend_d = {backend_q[23:0], ub};
        end
        pidx_d = pidx_inc;
        hbc_d  = hbc_dec;
        if (hbc_dec == 4'd0) begin
          if (mismatch) begin
            pidx_d  = accum_minus;
            phase_d = (accum_minus == 64'd0) ? PhB0 : PhSkip;
          end else if (cur_accum == BhdrLen64) begin
            phase_d = PhB0;
          end else begin
            phase_d = PhBody;
          end
        end
      end
      PhBody: begin
        pidx_d = pidx_inc;
        if (body_fin) begin
          phase_d = PhB0;
        end
      end
      PhSkip: begin
        if (cur_pidx != 64'd0) begin
          pidx_d = cur_pidx - 64'd1;
        end
        if ((cur_pidx == 64'd0) || (cur_pidx == 64'd1)) begin
          phase_d = PhB0;
        end
      end
      default: begin
        phase_d = PhB0;
      end
    endcase
  end

  always_comb begin
    logic       emit;
    logic       ids;
    logic [2:0] kind;
    logic [7:0] body;
    logic       last;
    emit = 1'b0;
    ids  = 1'b0;
    kind = KindBody;
    body = 8'd0;
    last = 1'b1;
    unique case (cur_phase)
      PhB1C: begin
        emit = 1'b1;
        kind = KindClose;
      end
      PhB1, PhL16, PhL64, PhDlen: begin
        if (len_event && !(in_b1 && ext_len) && !ld_drop) begin
          if (too_large) begin
            emit = 1'b1;
            kind = KindTooLarge;
          end else if (too_short) begin
            emit = 1'b1;
            kind = KindTooShort;
          end
        end
      end
      PhBhdr: begin
        if (hbc_dec == 4'd0) begin
          if (mismatch) begin
            emit = 1'b1;
            ids  = 1'b1;
            kind = KindMismatch;
          end else if (cur_accum == BhdrLen64) begin
            emit = 1'b1;
            ids  = 1'b1;
            kind = KindEmpty;
          end
        end
      end
      PhBody: begin
        emit = 1'b1;
        ids  = 1'b1;
        kind = KindBody;
        body = ub;
        last = body_fin;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    res_valid_o               = fire_i && emit;
    res_word_o.kind           = kind;
    res_word_o.body_byte      = body;
    res_word_o.peer_id        = ids ? client_d : 32'd0;
    res_word_o.route_id       = ids ? backend_d : 32'd0;
    res_word_o.message_length = ids ? blen_d[15:0] : 16'd0;
    res_word_o.last           = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhB0;
      final_q   <= 1'b0;
      masked_q  <= 1'b0;
      accum_q   <= 64'd0;
      hbc_q     <= 4'd0;
      mask_q    <= 32'd0;
      pidx_q    <= 64'd0;
      client_q  <= 32'd0;
      backend_q <= 32'd0;
      blen_q    <= 32'd0;
    end else if (fire_i) begin
      phase_q   <= phase_d;
      final_q   <= final_d;
      masked_q  <= masked_d;
      accum_q   <= accum_d;
      hbc_q     <= hbc_d;
      mask_q    <= mask_d;
      pidx_q    <= pidx_d;
      client_q  <= client_d;
      backend_q <= backend_d;
      blen_q    <= blen_d;
    end
  end

endmodule

`default_nettype wire
